// ----- rtl/rfps_pkg.sv -----
// Shared types, constants and arithmetic helpers of the real FFT power spectrum block.
`default_nettype none
package rfps_pkg;

	localparam int DATA_BITS = 32;
	localparam int POWER_BITS = 43;
	localparam int BIN_BITS = 6;
	localparam int TW_ADDR_BITS = 6;

	typedef logic signed [31:0] data_t;
	typedef logic signed [15:0] coef_t;

	// Quarter wave of cos(2*pi*k/64) in Q1.15, k = 0..16
	function automatic coef_t quarter_wave(input logic [4:0] k);
		coef_t v;
		case (k)
			5'd0: v = 16'sd32767;
			5'd1: v = 16'sd32610;
			5'd2: v = 16'sd32138;
			5'd3: v = 16'sd31357;
			5'd4: v = 16'sd30274;
			5'd5: v = 16'sd28899;
			5'd6: v = 16'sd27246;
			5'd7: v = 16'sd25330;
			5'd8: v = 16'sd23170;
			5'd9: v = 16'sd20788;
			5'd10: v = 16'sd18205;
			5'd11: v = 16'sd15447;
			5'd12: v = 16'sd12540;
			5'd13: v = 16'sd9512;
			5'd14: v = 16'sd6393;
			5'd15: v = 16'sd3212;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	// Cosine of twiddle k (k clamped to 32)
	function automatic coef_t tw_cos(input logic [TW_ADDR_BITS-1:0] k);
		logic [5:0] kk;
		kk = (k > 6'd32) ? 6'd32 : k;
		if (kk <= 6'd16) return quarter_wave(kk[4:0]);
		return -quarter_wave(5'(6'd32 - kk));
	endfunction

	// Sine of twiddle k (k clamped to 32)
	function automatic coef_t tw_sin(input logic [TW_ADDR_BITS-1:0] k);
		logic [5:0] kk;
		kk = (k > 6'd32) ? 6'd32 : k;
		if (kk <= 6'd16) return quarter_wave(5'(6'd16 - kk));
		return quarter_wave(5'(kk - 6'd16));
	endfunction

	// Saturate a wide signed value to 32 bits
	function automatic data_t sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) return 32'sh7fffffff;
		if (v < -50'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/real_fft_power_spectrum_top.sv -----
// Top level of the real FFT power spectrum block: sample store, sequencer and output.
//
// Collects input_length samples (clamped to 2..FFT_SIZE), zero-pads to the next power
// of two N, and emits N/2+1 power bins after the last sample of a frame. The block
// takes one sample per cycle while loading. After the last sample it is busy for the
// frame: it zeroes the padded entries, runs the FFT butterflies, the bit-reversal
// swaps, DC and Nyquist, the split butterflies and then the output bins, which wait
// on any sink stall. Both butterfly kinds use the single shared rotation unit, and the
// bin power comes from squaring the held magnitudes. The next sample waits until the
// last bin of the frame is taken.
`default_nettype none
module real_fft_power_spectrum_top #(
	parameter int FFT_SIZE = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,        // input_length in [6:0]
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // sample
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [55:0] m_tdata,                // power [42:0], bin_index [48:43]
	output logic m_tlast                        // bin_last
);
	localparam int H = FFT_SIZE / 2;
	localparam int AW = (H > 1) ? $clog2(H) : 1;
	localparam int CW = $clog2(FFT_SIZE) + 1;

	localparam logic [3:0] ST_LOAD = 4'd0, ST_PAD = 4'd1, ST_BF = 4'd2, ST_REV = 4'd3,
		ST_DC = 4'd4, ST_SPL = 4'd5, ST_OUT = 4'd6;

	logic [3:0] st_q;
	logic [6:0] len_q;
	logic [CW-1:0] cnt_q;
	logic [6:0] n_q;
	logic [2:0] ph_q;

	logic signed [31:0] wr_q [H];
	logic signed [31:0] wi_q [H];

	logic [6:0] len_c;
	always_comb begin
		len_c = len_q;
		if (len_c < 7'd2) len_c = 7'd2;
		if (len_c > 7'(FFT_SIZE)) len_c = 7'(FFT_SIZE);
	end

	// Padded size: smallest power of two at or above the length
	logic [6:0] n_c;
	always_comb begin
		n_c = 7'd2;
		for (int b = 2; b <= 6; b++)
			if ((7'd1 << (b - 1)) < len_c && (1 << b) <= FFT_SIZE) n_c = 7'(1 << b);
	end

	logic signed [31:0] x_c;
	assign x_c = 32'(signed'(s_tdata[SAMPLE_BITS-1:0]));

	assign s_tready = (st_q == ST_LOAD) && !m_tvalid;

	// FFT loop counters
	logic [6:0] span_q, j_q, i_q, skip_q;
	logic [AW-1:0] ia_q, la_q;
	logic signed [31:0] ar_q, ai_q, br_q, bi_q;
	logic signed [33:0] ma_q, mb_q;
	logic signed [15:0] mc_q, ms_q;
	logic signed [49:0] pac, pbs, pac_q, pbs_q;
	logic signed [31:0] rot_q;
	logic signed [33:0] t1_q, t2_q;
	logic [6:0] h_c;
	assign h_c = n_q >> 1;

	rfps_alu u_alu (.a(ma_q), .b(mb_q), .c(mc_q), .s(ms_q), .p_ac(pac), .p_bs(pbs));

	function automatic logic signed [31:0] rnd(input logic signed [49:0] x);
		return rfps_pkg::sat32((x + 50'sd16384) >>> 15);
	endfunction
	function automatic logic signed [31:0] hlv(input logic signed [49:0] x);
		return rfps_pkg::sat32((x + 50'sd1) >>> 1);
	endfunction
	function automatic logic [6:0] brev(input logic [6:0] k, input logic [6:0] hh);
		logic [6:0] r;
		r = '0;
		for (int b = 0; b < 6; b++)
			if ((7'd1 << b) < hh) r = {r[5:0], k[b]};
		return r;
	endfunction
	// 64 / p for a power of two p up to 64: mirror the seven bits
	function automatic logic [6:0] div64(input logic [6:0] p);
		logic [6:0] r;
		for (int b = 0; b < 7; b++) r[6 - b] = p[b];
		return r;
	endfunction
	// Magnitude for squaring; hold at 2^22, whose square alone passes the power cap
	function automatic logic [22:0] sq_mag(input logic signed [31:0] v);
		logic signed [32:0] w;
		w = 33'(v);
		if (w < 0) w = -w;
		if (w >= 33'sd4194304) return 23'h400000;
		return w[22:0];
	endfunction

	logic [6:0] kt_c;
	logic [6:0] rv_c;
	assign rv_c = brev(i_q, h_c);
	logic [6:0] tw_k;

	logic [45:0] pw_q;
	logic [42:0] pw_c;
	logic [5:0] outr_q;
	logic outi_q;
	logic [6:0] bin_q;

	always_comb begin
		kt_c = 7'(j_q * skip_q);
	end
	assign tw_k = kt_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			len_q <= 7'd64;
			cnt_q <= '0;
			n_q <= 7'd2;
			ph_q <= '0;
			m_tvalid <= 1'b0;
			span_q <= '0; j_q <= '0; i_q <= '0; skip_q <= '0; bin_q <= '0;
		end else begin
			if (cfg_wr_en) len_q <= cfg_wr_data[6:0];
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (st_q)
				// Store samples, even to real, odd to imaginary
				ST_LOAD: begin
					if (s_tvalid && s_tready) begin
						if (cnt_q < CW'(FFT_SIZE)) begin
							if (cnt_q[0]) wi_q[AW'(cnt_q >> 1)] <= x_c;
							else wr_q[AW'(cnt_q >> 1)] <= x_c;
						end
						if (7'(cnt_q) + 7'd1 < len_c) cnt_q <= cnt_q + 1'b1;
						else begin
							n_q <= n_c;
							cnt_q <= cnt_q + 1'b1;
							st_q <= ST_PAD;
						end
					end
				end
				// Zero the unfilled positions
				ST_PAD: begin
					if (7'(cnt_q) < n_q) begin
						if (cnt_q[0]) wi_q[AW'(cnt_q >> 1)] <= '0;
						else wr_q[AW'(cnt_q >> 1)] <= '0;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						span_q <= h_c; j_q <= '0; i_q <= '0;
						skip_q <= div64(h_c);
						ph_q <= '0;
						st_q <= (h_c > 7'd1) ? ST_BF : ST_REV;
					end
				end
				// One DIF butterfly in five steps
				ST_BF: begin
					case (ph_q)
						3'd0: begin
							ia_q <= AW'(i_q);
							la_q <= AW'(i_q + (span_q >> 1));
							ar_q <= wr_q[AW'(i_q)]; ai_q <= wi_q[AW'(i_q)];
							br_q <= wr_q[AW'(i_q + (span_q >> 1))];
							bi_q <= wi_q[AW'(i_q + (span_q >> 1))];
							ph_q <= 3'd1;
						end
						3'd1: begin
							wr_q[ia_q] <= rfps_pkg::sat32(50'(ar_q) + 50'(br_q));
							wi_q[ia_q] <= rfps_pkg::sat32(50'(ai_q) + 50'(bi_q));
							t1_q <= 34'(ar_q) - 34'(br_q);
							t2_q <= 34'(ai_q) - 34'(bi_q);
							ma_q <= 34'(ar_q) - 34'(br_q);
							mb_q <= 34'(ai_q) - 34'(bi_q);
							mc_q <= rfps_pkg::tw_cos(6'(tw_k));
							ms_q <= rfps_pkg::tw_sin(6'(tw_k));
							ph_q <= 3'd2;
						end
						3'd2: begin
							pac_q <= pac; pbs_q <= pbs;
							ma_q <= t2_q; mb_q <= -t1_q;
							ph_q <= 3'd3;
						end
						3'd3: begin
							wr_q[la_q] <= rnd(pac_q + pbs_q);
							pac_q <= pac; pbs_q <= pbs;
							ph_q <= 3'd4;
						end
						default: begin
							wi_q[la_q] <= rnd(pac_q + pbs_q);
							ph_q <= 3'd0;
							if (i_q + span_q + (span_q >> 1) < h_c + span_q &&
								i_q + span_q + (span_q >> 1) < h_c) i_q <= i_q + span_q;
							else if (j_q + 7'd1 < (span_q >> 1)) begin
								j_q <= j_q + 7'd1; i_q <= j_q + 7'd1;
							end else if ((span_q >> 1) > 7'd1) begin
								span_q <= span_q >> 1; skip_q <= skip_q << 1;
								j_q <= '0; i_q <= '0;
							end else begin
								i_q <= '0; st_q <= ST_REV;
							end
						end
					endcase
				end
				// Bit-reversal swap, one index per step
				ST_REV: begin
					if (ph_q == 3'd0) begin
						ar_q <= wr_q[AW'(i_q)]; ai_q <= wi_q[AW'(i_q)];
						br_q <= wr_q[AW'(rv_c)]; bi_q <= wi_q[AW'(rv_c)];
						ph_q <= 3'd1;
					end else begin
						ph_q <= 3'd0;
						if (rv_c > i_q && rv_c < h_c) begin
							wr_q[AW'(i_q)] <= br_q; wi_q[AW'(i_q)] <= bi_q;
							wr_q[AW'(rv_c)] <= ar_q; wi_q[AW'(rv_c)] <= ai_q;
						end
						if (i_q + 7'd1 < h_c) i_q <= i_q + 7'd1;
						else st_q <= ST_DC;
					end
				end
				// DC and Nyquist
				ST_DC: begin
					wr_q[0] <= rfps_pkg::sat32(50'(wr_q[0]) + 50'(wi_q[0]));
					wi_q[0] <= rfps_pkg::sat32(50'(wr_q[0]) - 50'(wi_q[0]));
					j_q <= 7'd1; ph_q <= '0;
					st_q <= (n_q >= 7'd4) ? ST_SPL : ST_OUT;
					bin_q <= '0;
				end
				// Split butterfly for bins j and h-j
				ST_SPL: begin
					case (ph_q)
						3'd0: begin
							ar_q <= wr_q[AW'(j_q)]; ai_q <= wi_q[AW'(j_q)];
							br_q <= wr_q[AW'(h_c - j_q)]; bi_q <= wi_q[AW'(h_c - j_q)];
							ph_q <= 3'd1;
						end
						3'd1: begin
							t1_q <= 34'(br_q) + 34'(ar_q);
							t2_q <= 34'(ai_q) - 34'(bi_q);
							ma_q <= 34'(ai_q) + 34'(bi_q);
							mb_q <= 34'(br_q) - 34'(ar_q);
							mc_q <= rfps_pkg::tw_cos(6'(j_q * div64(n_q)));
							ms_q <= rfps_pkg::tw_sin(6'(j_q * div64(n_q)));
							ph_q <= 3'd2;
						end
						3'd2: begin
							pac_q <= pac; pbs_q <= pbs;
							ma_q <= mb_q; mb_q <= -ma_q;
							ph_q <= 3'd3;
						end
						3'd3: begin
							rot_q <= rnd(pac_q + pbs_q);
							pac_q <= pac; pbs_q <= pbs;
							ph_q <= 3'd4;
						end
						default: begin
							// at the middle bin both halves share one entry; the mirror half wins
							if (j_q != h_c - j_q) begin
								wr_q[AW'(j_q)] <= hlv(50'(t1_q) + 50'(rot_q));
								wi_q[AW'(j_q)] <= hlv(50'(t2_q) + 50'(rnd(pac_q + pbs_q)));
							end
							wr_q[AW'(h_c - j_q)] <= hlv(50'(t1_q) - 50'(rot_q));
							wi_q[AW'(h_c - j_q)] <= hlv(50'(rnd(pac_q + pbs_q)) - 50'(t2_q));
							ph_q <= '0;
							if (j_q < (n_q >> 2)) j_q <= j_q + 7'd1;
							else st_q <= ST_OUT;
						end
					endcase
				end
				// Power per bin: square the held magnitudes, then send
				default: begin
					if (ph_q == 3'd0) begin
						if (!m_tvalid || m_tready) begin
							ma_q <= 34'(sq_mag((bin_q == 7'd0) ? wr_q[0] :
								(bin_q == h_c) ? wi_q[0] : wr_q[AW'(bin_q)]));
							mb_q <= (bin_q == 7'd0 || bin_q == h_c) ? 34'sd0 :
								34'(sq_mag(wi_q[AW'(bin_q)]));
							ph_q <= 3'd1;
						end
					end else begin
						m_tvalid <= 1'b1;
						pw_q <= 46'(ma_q[22:0]) * 46'(ma_q[22:0]) +
							46'(mb_q[22:0]) * 46'(mb_q[22:0]);
						outr_q <= bin_q[5:0];
						outi_q <= (bin_q == h_c);
						ph_q <= '0;
						if (bin_q == h_c) begin
							st_q <= ST_LOAD; cnt_q <= '0;
						end else bin_q <= bin_q + 7'd1;
					end
				end
			endcase
		end
	end

	assign pw_c = (pw_q > 46'h7ffffffffff) ? 43'h7ffffffffff : pw_q[42:0];
	assign m_tdata = {7'd0, outr_q, pw_c};
	assign m_tlast = outi_q;
endmodule
`default_nettype wire

// ----- rtl/rfps_alu.sv -----
// Shared arithmetic unit: the two products of one rotation.
`default_nettype none
module rfps_alu (
	input  wire logic signed [33:0] a,
	input  wire logic signed [33:0] b,
	input  wire logic signed [15:0] c,
	input  wire logic signed [15:0] s,
	output logic signed [49:0] p_ac,
	output logic signed [49:0] p_bs
);
	// Two products of one rotation; summed and rounded by the sequencer after a register
	always_comb begin
		p_ac = 50'(a * c);
		p_bs = 50'(b * s);
	end
endmodule
`default_nettype wire

// ----- verif/rfps_spectrum_checker.sv -----
// Checker for the real FFT power spectrum block: predicts bins from accepted samples.
`timescale 1ns / 100ps
module rfps_spectrum_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic s_tvalid,
	input  wire logic s_tready,
	input  wire logic [15:0] s_tdata,
	input  wire logic m_tvalid,
	input  wire logic m_tready,
	input  wire logic [55:0] m_tdata,
	input  wire logic m_tlast,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic [42:0] power;
		logic [5:0] bin;
		logic last;
	} bin_beat_t;

	localparam longint POWER_CAP = (64'd1 << 43) - 1;

	bin_beat_t bin_queue[$];
	logic [6:0] frame_len;
	int fill_count;
	rfps_pkg::data_t acc_re[32];
	rfps_pkg::data_t acc_im[32];
	int cos_tab[33];
	int sin_tab[33];

	// Q1.15 quarter wave of the twiddle circle
	function automatic int quarter(input int k);
		int q[17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
			20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
		return q[k];
	endfunction

	initial begin
		for (int k = 0; k <= 32; k++) begin
			cos_tab[k] = (k <= 16) ? quarter(k) : -quarter(32 - k);
			sin_tab[k] = (k <= 16) ? quarter(16 - k) : quarter(k - 16);
		end
	end

	function automatic rfps_pkg::data_t clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic rfps_pkg::data_t twist(input longint a, input longint c,
		input longint b, input longint s);
		longint p;
		p = a * c + b * s + 64'sd16384;
		return clip32(p >>> 15);
	endfunction

	function automatic rfps_pkg::data_t halve_round(input longint v);
		return clip32((v + 1) >>> 1);
	endfunction

	function automatic logic [42:0] bin_power(input rfps_pkg::data_t re,
		input rfps_pkg::data_t im);
		logic [63:0] a, b, p;
		a = (re < 0) ? 64'(-longint'(re)) : 64'(longint'(re));
		b = (im < 0) ? 64'(-longint'(im)) : 64'(longint'(im));
		p = a * a + b * b;
		return (p > POWER_CAP) ? POWER_CAP[42:0] : p[42:0];
	endfunction

	// Run the half-size complex DIF FFT in place, then bit-reverse
	task automatic complex_dif(input int h);
		int stride, span, skip, bits, half, l, r, tk;
		longint c, s, xt, yt;
		rfps_pkg::data_t t;
		stride = 64 / h;
		span = h;
		skip = 1;
		bits = 0;
		while ((1 << bits) < h) bits++;
		while (span > 1) begin
			half = span / 2;
			for (int j = 0; j < half; j++) begin
				tk = j * skip * stride;
				if (tk > 32) tk = 32;
				c = cos_tab[tk];
				s = sin_tab[tk];
				for (int i = j; i + half < h; i += span) begin
					l = i + half;
					xt = longint'(acc_re[i]) - acc_re[l];
					yt = longint'(acc_im[i]) - acc_im[l];
					acc_re[i] = clip32(longint'(acc_re[i]) + acc_re[l]);
					acc_im[i] = clip32(longint'(acc_im[i]) + acc_im[l]);
					acc_re[l] = twist(xt, c, yt, s);
					acc_im[l] = twist(yt, c, -xt, s);
				end
			end
			span = half;
			skip *= 2;
		end
		for (int k = 0; k < h; k++) begin
			r = 0;
			for (int b = 0; b < bits; b++)
				if ((k >> b) & 1) r |= 1 << (bits - 1 - b);
			if (r > k && r < h) begin
				t = acc_re[r]; acc_re[r] = acc_re[k]; acc_re[k] = t;
				t = acc_im[r]; acc_im[r] = acc_im[k]; acc_im[k] = t;
			end
		end
	endtask

	// Store one sample; on the closing sample compute and queue all bins
	task automatic take_sample(input logic signed [15:0] x);
		int len, c, n, h, q, j2, tk;
		longint cw, sw, tr1, ti1, tr2, ti2, xr, xi, r0, i0;
		bin_beat_t bb;
		len = frame_len;
		if (len < 2) len = 2;
		if (len > 64) len = 64;
		c = fill_count;
		if (c < 64) begin
			if (c & 1) acc_im[c >> 1] = x;
			else acc_re[c >> 1] = x;
		end
		if (c + 1 < len) begin
			fill_count = c + 1;
			return;
		end
		fill_count = 0;
		n = 1;
		while (n < len && n * 2 <= 64) n *= 2;
		for (int b = c + 1; b < n; b++) begin
			if (b & 1) acc_im[b >> 1] = 0;
			else acc_re[b >> 1] = 0;
		end
		h = n / 2;
		complex_dif(h);
		r0 = acc_re[0];
		i0 = acc_im[0];
		acc_re[0] = clip32(r0 + i0);
		acc_im[0] = clip32(r0 - i0);
		// Split butterflies; at the middle bin the mirror write lands last
		q = n / 4;
		for (int j1 = 1; j1 <= q; j1++) begin
			j2 = h - j1;
			tk = j1 * (64 / n);
			if (tk > 32) tk = 32;
			cw = cos_tab[tk];
			sw = sin_tab[tk];
			tr1 = longint'(acc_re[j2]) + acc_re[j1];
			ti1 = longint'(acc_im[j1]) - acc_im[j2];
			tr2 = longint'(acc_im[j1]) + acc_im[j2];
			ti2 = longint'(acc_re[j2]) - acc_re[j1];
			xr = twist(tr2, cw, ti2, sw);
			xi = twist(ti2, cw, -tr2, sw);
			acc_re[j1] = halve_round(tr1 + xr);
			acc_im[j1] = halve_round(ti1 + xi);
			acc_re[j2] = halve_round(tr1 - xr);
			acc_im[j2] = halve_round(xi - ti1);
		end
		for (int b = 0; b <= h; b++) begin
			if (b == 0) bb.power = bin_power(acc_re[0], 0);
			else if (b == h) bb.power = bin_power(acc_im[0], 0);
			else bb.power = bin_power(acc_re[b], acc_im[b]);
			bb.bin = 6'(b);
			bb.last = (b == h);
			bin_queue.push_back(bb);
		end
	endtask

	assign pending = bin_queue.size();

	// Track config and samples, compare each output beat against the oldest bin
	always @(posedge clk or negedge arst_n) begin
		bin_beat_t want;
		if (!arst_n) begin
			frame_len <= 7'd64;
			fill_count = 0;
			bin_queue.delete();
			fail_count <= 0;
		end else begin
			if (cfg_wr_en) frame_len <= cfg_wr_data[6:0];
			if (s_tvalid && s_tready) take_sample(s_tdata);
			if (m_tvalid && m_tready) begin
				if (bin_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected bin beat: data=%h last=%b", m_tdata, m_tlast);
					fail_count <= fail_count + 1;
				end else begin
					want = bin_queue.pop_front();
					if (m_tdata[42:0] !== want.power || m_tdata[48:43] !== want.bin ||
							m_tdata[55:49] !== 7'd0 || m_tlast !== want.last) begin
						if (fail_count < 10)
							$display("bin mismatch: exp p=%0d b=%0d l=%b got p=%0d b=%0d l=%b",
								want.power, want.bin, want.last,
								m_tdata[42:0], m_tdata[48:43], m_tlast);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ----- verif/real_fft_power_spectrum_top_test.sv -----
// Testbench top for the real FFT power spectrum block: stimulus, sink and verdict.
`timescale 1ns / 100ps
module real_fft_power_spectrum_top_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = 16'd0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic m_tlast;
	int fail_count;
	int pending;
	int sent = 0;
	int stall_free = 0;
	int quiet_cycles = 0;

	localparam int WATCHDOG_LIMIT = 20000;

	always #5 clk = ~clk;

	real_fft_power_spectrum_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	rfps_spectrum_checker spectrum_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	// Send one sample beat, after a random gap unless stall_free is set
	task automatic send_sample(input logic [15:0] v);
		int gap;
		gap = stall_free ? 0 : $urandom_range(3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		sent++;
	endtask

	// Write frame length once the block has drained
	task automatic set_length(input logic [7:0] v);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [15:0] pick_sample(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
			2: return 16'($urandom_range(0, 255) - 128);
			default: return $urandom_range(1) ? 16'h7fff : 16'($urandom);
		endcase
	endfunction

	// Sink: ready after a random gap per beat unless stall_free is set
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = stall_free ? 0 : $urandom_range(3);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [7:0] lens[16] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9, 8'd16, 8'd31,
			8'd32, 8'd33, 8'd63, 8'd64, 8'd0, 8'd1, 8'd100, 8'd255};
		int len, frames, mode, part;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes on short frames, length clamps, mid-frame change
		set_length(8'd2);
		send_sample(16'h7fff); send_sample(16'h7fff);
		send_sample(16'h8000); send_sample(16'h8000);
		send_sample(16'h7fff); send_sample(16'h8000);
		send_sample(16'h0000); send_sample(16'hffff);
		set_length(8'd0);
		send_sample(16'h8000); send_sample(16'h0001);
		set_length(8'd131);
		send_sample(16'h7fff); send_sample(16'h8000); send_sample(16'h5555);
		set_length(8'd4);
		send_sample(16'haaaa); send_sample(16'h8000); send_sample(16'h7fff);
		send_sample(16'h8000);
		set_length(8'd64);
		repeat (6) send_sample(16'h7fff);
		// shorten mid-frame; later samples past N get dropped
		set_length(8'd4);
		send_sample(16'h8000);

		// Random phases of lengths, content styles and stall modes
		while (sent < 370) begin
			len = lens[$urandom_range(15)];
			set_length(8'(len) | ($urandom_range(1) ? 8'h80 : 8'h00));
			stall_free = ($urandom_range(3) == 0);
			mode = $urandom_range(3);
			frames = $urandom_range(1, 3);
			if (($urandom_range(4) == 0)) begin
				part = $urandom_range(1, 40);
				repeat (part) send_sample(pick_sample(mode));
				set_length(8'($urandom_range(2, 64)));
			end
			len = len & 8'h7f;
			if (len < 2) len = 2;
			if (len > 64) len = 64;
			repeat (frames * len) send_sample(pick_sample(mode));
		end

		// Drain and settle
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

// ----- filelist.f -----
rtl/rfps_pkg.sv
rtl/rfps_alu.sv
rtl/real_fft_power_spectrum_top.sv
verif/rfps_spectrum_checker.sv
verif/real_fft_power_spectrum_top_test.sv
